// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned PRIO_W    = 8;
	localparam int unsigned DATA_W    = 16;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned OCC_W     = 5;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                     gt;
		logic [PRIO_W-1:0]        prio;
		logic signed [DATA_W-1:0] data;
	} spq_link_t;

endpackage

`default_nettype wire

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
	input  wire logic                              clk,
	input  wire logic                              ins_en,
	input  wire logic                              rem_en,
	input  wire logic                              occ,
	input  wire logic [spq_pkg::PRIO_W-1:0]        new_prio,
	input  wire logic signed [spq_pkg::DATA_W-1:0] new_data,
	input  wire spq_pkg::spq_link_t                left,
	input  wire spq_pkg::spq_link_t                right,
	output spq_pkg::spq_link_t                     self
);
	import spq_pkg::*;

	logic [PRIO_W-1:0]        prio_q;
	logic signed [DATA_W-1:0] data_q;

	// later than the new entry, or empty
	assign self.gt   = !occ || (prio_q > new_prio);
	assign self.prio = prio_q;
	assign self.data = data_q;

	always_ff @(posedge clk) begin
		if (ins_en && self.gt) begin
			if (left.gt) begin
				prio_q <= left.prio;
				data_q <= left.data;
			end else begin
				prio_q <= new_prio;
				data_q <= new_data;
			end
		end else if (rem_en) begin
			prio_q <= right.prio;
			data_q <= right.data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue_top.sv -----
// result: an accepted request's result is registered and appears on the master side in the cycle after
// throughput: one request per cycle while results are taken; each cell compares
// against the new entry and shifts from a neighbour in the same cycle
// reset: entry count and result valid cleared; cell contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_top #(
	parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // priority_req[7:0], payload[23:8]
	input  wire logic        s_tuser,  // cmd[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // out_priority[7:0], out_payload[23:8], occupancy[28:24]
	output logic [1:0]       m_tuser   // status[1:0]
);
	import spq_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nx;
	logic [CNT_W+OCC_W-1:0]   count_ext;
	logic                     m_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic [PRIO_W-1:0]        prio_q;
	logic signed [DATA_W-1:0] data_q;
	logic [OCC_W-1:0]         occ_q;

	logic                     acc;
	logic                     is_rem;
	logic                     full;
	logic                     empty;
	logic                     ins_en;
	logic                     rem_en;
	logic [PRIO_W-1:0]        new_prio;
	logic signed [DATA_W-1:0] new_data;
	logic [STAT_W-1:0]        status_nx;

	spq_link_t links [DEPTH];
	spq_link_t edge_link;

	assign new_prio  = s_tdata[PRIO_W-1:0];
	assign new_data  = s_tdata[PRIO_W+DATA_W-1:PRIO_W];
	assign is_rem    = (s_tuser == CMD_REMOVE);
	assign s_tready  = !m_valid_q || m_tready;
	assign acc       = s_tvalid && s_tready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign ins_en    = acc && !is_rem && !full;
	assign rem_en    = acc && is_rem && !empty;
	assign edge_link = '0;

	always_comb begin
		count_nx  = count_q;
		status_nx = ST_OK;
		if (is_rem) begin
			if (empty) begin
				status_nx = ST_EMPTY;
			end else begin
				count_nx = count_q - 1'b1;
			end
		end else begin
			if (full) begin
				status_nx = ST_FULL;
			end else begin
				count_nx = count_q + 1'b1;
			end
		end
	end

	assign count_ext = {{OCC_W{1'b0}}, count_nx};

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			spq_link_t left_l;
			spq_link_t right_l;
			logic      occ_l;

			if (gi == 0) begin : g_first
				assign left_l = edge_link;
			end else begin : g_mid
				assign left_l = links[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign right_l = edge_link;
			end else begin : g_inner
				assign right_l = links[gi+1];
			end
			assign occ_l = (count_q > CNT_W'(gi));

			spq_cell u_cell (
				.clk     (clk),
				.ins_en  (ins_en),
				.rem_en  (rem_en),
				.occ     (occ_l),
				.new_prio(new_prio),
				.new_data(new_data),
				.left    (left_l),
				.right   (right_l),
				.self    (links[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q   <= count_nx;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= status_nx;
			occ_q    <= count_ext[OCC_W-1:0];
			if (rem_en) begin
				prio_q <= links[0].prio;
				data_q <= links[0].data;
			end else begin
				prio_q <= '0;
				data_q <= '0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, occ_q, data_q, prio_q};

endmodule

`default_nettype wire

// ----- rtl/spq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_checker #(
	parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	import spq_pkg::*;

	localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// every accepted request yields a result next cycle
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after request");

	// free output register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// empty remove returns nothing and zero occupancy
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[28:0] == 29'd0))
		else $error("bad empty result");

	// full insert reports a full queue
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |->
			(m_tdata[28:24] == DEPTH_OCC) && (m_tdata[23:0] == 24'd0))
		else $error("bad full result");

endmodule

bind sorted_priority_queue_top spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import spq_pkg::*;

	localparam int unsigned QDEPTH      = DEPTH_DEF;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned REPORT_MAX  = 20;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic [PRIO_W-1:0]        prio;
		logic signed [DATA_W-1:0] data;
		logic [OCC_W-1:0]         occ;
	} outcome_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        s_tuser  = CMD_INSERT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	logic [PRIO_W-1:0]        held_prio [QDEPTH];
	logic signed [DATA_W-1:0] held_data [QDEPTH];
	int unsigned              held_count = 0;
	outcome_t                 pending_results [$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned error_count    = 0;

	sorted_priority_queue_top #(.DEPTH(QDEPTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sorted insert after equal priorities, head removal
	function automatic outcome_t queue_apply(input logic cmd, input logic [PRIO_W-1:0] prio,
			input logic signed [DATA_W-1:0] data);
		outcome_t    res;
		int unsigned pos;
		res = '0;
		res.status = ST_OK;
		if (cmd == CMD_INSERT) begin
			if (held_count >= QDEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_prio[pos] <= prio)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_prio[i] = held_prio[i-1];
					held_data[i] = held_data[i-1];
				end
				held_prio[pos] = prio;
				held_data[pos] = data;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.prio = held_prio[0];
				res.data = held_data[0];
				for (int i = 1; i < held_count; i++) begin
					held_prio[i-1] = held_prio[i];
					held_data[i-1] = held_data[i];
				end
				held_count--;
			end
		end
		res.occ = held_count[OCC_W-1:0];
		return res;
	endfunction

	task automatic send_request(input logic cmd, input logic [PRIO_W-1:0] prio,
			input logic signed [DATA_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {data, prio};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(queue_apply(cmd, prio, data));
	endtask

	function automatic void check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			error_count++;
			if (error_count <= REPORT_MAX)
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, name, exp_val, act_val);
		end
	endfunction

	always @(posedge clk) begin
		outcome_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_MAX)
					$display("%0t: unexpected result, expected none, actual status %0d",
						$time, m_tuser);
			end else begin
				exp_res = pending_results.pop_front();
				check_field("status", exp_res.status, m_tuser);
				check_field("out_priority", exp_res.prio, m_tdata[7:0]);
				check_field("out_payload", exp_res.data, $signed(m_tdata[23:8]));
				check_field("occupancy", exp_res.occ, m_tdata[28:24]);
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic test_empty_remove();
		send_request(CMD_REMOVE, 8'hFF, 16'sh7FFF);
	endtask

	// head, tail, middle and tied inserts with extreme payloads
	task automatic test_fill_order();
		logic [PRIO_W-1:0]        prios [QDEPTH];
		logic signed [DATA_W-1:0] datas [QDEPTH];
		prios = '{8'd128, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd64, 8'd128,
			8'd1, 8'd254, 8'd128, 8'd0, 8'd127, 8'd129, 8'd255, 8'd64};
		datas = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sh5555, -16'sh5556,
			16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 16'sd9, 16'sd10};
		for (int i = 0; i < QDEPTH; i++)
			send_request(CMD_INSERT, prios[i], datas[i]);
	endtask

	task automatic test_insert_when_full();
		send_request(CMD_INSERT, 8'd0, -16'sd32768);
	endtask

	task automatic test_remove_order();
		for (int i = 0; i < 4; i++)
			send_request(CMD_REMOVE, 8'($urandom), 16'($urandom));
	endtask

	// bursts with a drifting insert bias so the queue swings between empty and full
	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned count);
		int unsigned       bias;
		logic              cmd;
		logic [PRIO_W-1:0] prio;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		bias = 50;
		for (int unsigned n = 0; n < count; n++) begin
			if (n % 32 == 0) begin
				case ($urandom_range(3))
					0: bias = 15;
					1: bias = 85;
					default: bias = 50;
				endcase
			end
			cmd = ($urandom_range(99) < bias) ? CMD_INSERT : CMD_REMOVE;
			case ($urandom_range(3))
				0: prio = 8'($urandom_range(0, 3));
				1: prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				2: prio = 8'($urandom_range(120, 135));
				default: prio = 8'($urandom);
			endcase
			send_request(cmd, prio, 16'($urandom));
		end
	endtask

	initial begin
		for (int i = 0; i < QDEPTH; i++) begin
			held_prio[i] = '0;
			held_data[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_remove();
		test_fill_order();
		test_insert_when_full();
		test_remove_order();
		test_random_traffic(0, 0, 460);
		test_random_traffic(65, 0, 460);
		test_random_traffic(0, 65, 460);
		test_random_traffic(12, 12, 460);

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
